@@ hw/rtl/chacha20_keystream_xor_macros.svh @@
// Assertion macros for the keystream block's checker.
// Uses the checker's own i_clk and i_rst_n; include by bare file name.
`ifndef CHACHA20_KEYSTREAM_XOR_MACROS_SVH
`define CHACHA20_KEYSTREAM_XOR_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define CHX_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define CHX_ASSERT_NXT(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define CHX_ASSERT_NXT_ALWAYS(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) (cond) |=> (prop)) else $error(msg);

`endif

@@ hw/rtl/chx_pkg.sv @@
// Shared types, constants and the ChaCha20 state setup.
// No dependencies; imported by all chx modules.
`timescale 1ns / 1ps
`default_nettype none

package chx_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam int ROUNDS      = 20;
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 64;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_KEY01 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY23 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY45 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY67 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_IV01  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_IV23  = 3'd5;

    // command codes carried in tuser
    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    typedef logic [15:0][31:0] t_words;
    typedef logic [3:0][63:0]  t_key;

    // one queued input beat
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       last;
    } t_item;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    function automatic t_words init_state(input t_key key, input logic [31:0] ctr,
                                          input logic [31:0] nonce1,
                                          input logic [63:0] iv23);
        t_words w;
        w[0]  = SIGMA0;
        w[1]  = SIGMA1;
        w[2]  = SIGMA2;
        w[3]  = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            w[4 + 2*i] = key[i][31:0];
            w[5 + 2*i] = key[i][63:32];
        end
        w[12] = ctr;
        w[13] = nonce1;
        w[14] = iv23[31:0];
        w[15] = iv23[63:32];
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/chacha20_keystream_xor.sv @@
// Channel    Dir  Beat contents
// s_axis     in   tdata[7:0] data byte, tuser command (1 = restart), tlast end of message
// m_axis     out  tdata[7:0] data byte XOR keystream byte
// cfg        in   i_cfg_addr register index 0..5, i_cfg_wdata 64-bit value, no read-back
//
// A data beat passes when the keystream block is already held and the output
// register is free. The first byte of every 64-byte block waits for the block
// refill: one load, 80 quarter-round steps (20 rounds x 4) and one feed-forward
// step. Restart beats are consumed and give no output.
// Synchronous active-low reset; the input queue keeps accepting, until it is
// full, while the core computes or the output register is stalled.
`timescale 1ns / 1ps
`default_nettype none

module chacha20_keystream_xor import chx_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [7:0]            i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic                  i_s_axis_tuser,   // [0] command
    input  wire logic                  i_s_axis_tlast,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [7:0]                 o_m_axis_tdata,   // [7:0] out_byte
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_item w_item;
    t_head w_head;
    logic  w_pop;

    assign w_item.cmd  = i_s_axis_tuser;
    assign w_item.data = i_s_axis_tdata;
    assign w_item.last = i_s_axis_tlast;

    chx_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (w_item),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    chx_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ hw/rtl/chx_front.sv @@
// Input side: takes stream beats and holds them in a short queue.
// Depends on chx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chx_front import chx_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output t_head      o_head,
    input  wire logic  i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/chx_core.sv @@
// Back end: config registers, counters, round engine and output register.
// Depends on chx_pkg. One quarter-round step per cycle on all four lanes.
`timescale 1ns / 1ps
`default_nettype none

module chx_core import chx_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire t_head                 i_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_data
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ROUND = 3'b010,
        S_FINAL = 3'b100
    } t_state;

    t_state               r_state, n_state;
    t_key                 r_key;
    logic [63:0]          r_iv01;
    logic [63:0]          r_iv23;
    logic [31:0]          r_ctr, n_ctr;
    logic [31:0]          r_nonce1, n_nonce1;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_have, n_have;
    logic [1:0]           r_step, n_step;
    logic [ROUND_W-1:0]   r_round, n_round;
    t_words               r_x, n_x;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_data, n_out_data;

    t_words               w_init;
    t_words               w_rnd;
    logic [31:0]          w_word;
    logic [7:0]           w_ks;
    logic                 w_out_free;

    // one of the four add/xor/rotate steps of a quarter round
    function automatic logic [127:0] qr_step(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d,
                                             input logic [1:0] st);
        logic [31:0] s;
        logic [31:0] t;
        case (st)
            2'd0: begin
                s = a + b;
                t = d ^ s;
                return {s, b, c, {t[15:0], t[31:16]}};
            end
            2'd1: begin
                s = c + d;
                t = b ^ s;
                return {a, {t[19:0], t[31:20]}, s, d};
            end
            2'd2: begin
                s = a + b;
                t = d ^ s;
                return {s, b, c, {t[23:0], t[31:24]}};
            end
            default: begin
                s = c + d;
                t = b ^ s;
                return {a, {t[24:0], t[31:25]}, s, d};
            end
        endcase
    endfunction

    assign w_init = init_state(r_key, r_ctr, r_nonce1, r_iv23);

    // even rounds work on columns, odd rounds on diagonals
    always_comb begin
        logic [1:0]   lb;
        logic [1:0]   lc;
        logic [1:0]   ld;
        logic         diag;
        logic [127:0] q;
        w_rnd = r_x;
        diag  = r_round[0];
        for (int j = 0; j < 4; j++) begin
            lb = 2'(j) + {1'b0, diag};
            lc = 2'(j) + {diag, 1'b0};
            ld = 2'(j) + {diag, diag};
            q  = qr_step(r_x[j], r_x[{2'b01, lb}], r_x[{2'b10, lc}], r_x[{2'b11, ld}],
                         r_step);
            w_rnd[j]            = q[127:96];
            w_rnd[{2'b01, lb}]  = q[95:64];
            w_rnd[{2'b10, lc}]  = q[63:32];
            w_rnd[{2'b11, ld}]  = q[31:0];
        end
    end

    assign w_word     = r_x[r_pos[POS_W-1:2]];
    assign w_ks       = w_word[{r_pos[1:0], 3'b000} +: 8];
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_ctr       = r_ctr;
        n_nonce1    = r_nonce1;
        n_pos       = r_pos;
        n_have      = r_have;
        n_step      = r_step;
        n_round     = r_round;
        n_x         = r_x;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.item.cmd == CMD_RESTART) begin
                        n_ctr    = r_iv01[31:0];
                        n_nonce1 = r_iv01[63:32];
                        n_pos    = '0;
                        n_have   = 1'b0;
                        o_pop    = 1'b1;
                    end else if (r_pos == '0 && !r_have) begin
                        n_x     = w_init;
                        n_step  = '0;
                        n_round = '0;
                        n_state = S_ROUND;
                    end else if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = i_head.item.data ^ w_ks;
                        n_have      = 1'b0;
                        n_pos       = r_pos + 1'b1;
                        o_pop       = 1'b1;
                        if (r_pos == POS_W'(BLOCK_BYTES - 1)) begin
                            {n_nonce1, n_ctr} = {r_nonce1, r_ctr} + 64'd1;
                        end
                    end
                end
            end
            S_ROUND: begin
                n_x    = w_rnd;
                n_step = r_step + 1'b1;
                if (r_step == 2'd3) begin
                    n_round = r_round + 1'b1;
                    if (r_round == ROUND_W'(ROUNDS - 1)) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                for (int i = 0; i < 16; i++) begin
                    n_x[i] = r_x[i] + w_init[i];
                end
                n_have  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key       <= '0;
            r_iv01      <= '0;
            r_iv23      <= '0;
            r_ctr       <= '0;
            r_nonce1    <= '0;
            r_pos       <= '0;
            r_have      <= 1'b0;
            r_step      <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ctr       <= n_ctr;
            r_nonce1    <= n_nonce1;
            r_pos       <= n_pos;
            r_have      <= n_have;
            r_step      <= n_step;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_KEY01, REG_KEY23, REG_KEY45, REG_KEY67: begin
                        r_key[i_cfg_addr[1:0]] <= i_cfg_wdata;
                    end
                    REG_IV01: r_iv01 <= i_cfg_wdata;
                    REG_IV23: r_iv23 <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_out_data <= n_out_data;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

@@ hw/rtl/chx_checker.sv @@
// Port-level checks for chacha20_keystream_xor, attached by bind.
// Depends on chx_pkg and chacha20_keystream_xor_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "chacha20_keystream_xor_macros.svh"

module chx_checker import chx_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic                  i_s_axis_tuser,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [7:0]            o_m_axis_tdata
);

    // data beats taken in but not yet delivered
    logic [7:0] r_pending;
    logic       w_in_data;
    logic       w_out_beat;

    assign w_in_data  = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == CMD_DATA);
    assign w_out_beat = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {7'd0, w_in_data} - {7'd0, w_out_beat};
        end
    end

    `CHX_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "output beat dropped while stalled")
    `CHX_ASSERT_NXT(a_out_stable, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata), "output data changed while stalled")
    `CHX_ASSERT_IMP(a_no_invented, o_m_axis_tvalid, r_pending != 8'd0, "output beat without a pending data beat")
    `CHX_ASSERT_NXT_ALWAYS(a_reset_quiet, !i_rst_n, !o_m_axis_tvalid, "output valid right after reset")

endmodule

bind chacha20_keystream_xor chx_checker u_chx_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking bench for chacha20_keystream_xor: byte stream in, XORed stream out.
// Holds its own ChaCha20 keystream predictor and scoreboard; needs chx_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import chx_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS    = 100;

    // indexes past the last register; writes there must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE7 = 3'd7;

    localparam logic [31:0] CONST_W0 = 32'h6170_7865;
    localparam logic [31:0] CONST_W1 = 32'h3320_646e;
    localparam logic [31:0] CONST_W2 = 32'h7962_2d32;
    localparam logic [31:0] CONST_W3 = 32'h6b20_6574;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  s_tuser  = CMD_DATA;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    chacha20_keystream_xor i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // cipher shadow state
    logic [63:0]      key_cfg [4];
    logic [63:0]      iv01_cfg = '0;
    logic [63:0]      iv23_cfg = '0;
    logic [31:0]      blk_ctr  = '0;
    logic [31:0]      nonce1   = '0;
    logic [POS_W-1:0] ks_pos   = '0;
    logic [7:0]       ks_buf  [BLOCK_BYTES];
    logic [31:0]      mix     [16];

    t_item      pending_beats[$];
    logic [7:0] expected_out_bytes[$];

    int tx_idle_pct = 21;
    int rx_idle_pct = 75;
    int rx_hold_requests = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    bit s_accepted = 1'b0;
    int quiet_cycles = 0;
    int err_count = 0;
    int data_beats = 0;
    int restart_beats = 0;
    int blocks_made = 0;
    int ctr_wraps = 0;
    int nonce_wraps = 0;
    logic [7:0] want_byte;
    t_item next_beat;

    initial begin
        for (int i = 0; i < 4; i++) key_cfg[i] = '0;
        for (int i = 0; i < BLOCK_BYTES; i++) ks_buf[i] = '0;
    end

    function automatic logic [31:0] rotl32(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void mix_quarter(int a, int b, int c, int d);
        mix[a] = mix[a] + mix[b]; mix[d] = rotl32(mix[d] ^ mix[a], 16);
        mix[c] = mix[c] + mix[d]; mix[b] = rotl32(mix[b] ^ mix[c], 12);
        mix[a] = mix[a] + mix[b]; mix[d] = rotl32(mix[d] ^ mix[a], 8);
        mix[c] = mix[c] + mix[d]; mix[b] = rotl32(mix[b] ^ mix[c], 7);
    endfunction

    function automatic void refill_keystream();
        logic [31:0] start_words [16];
        logic [31:0] w;
        start_words[0] = CONST_W0;
        start_words[1] = CONST_W1;
        start_words[2] = CONST_W2;
        start_words[3] = CONST_W3;
        for (int i = 0; i < 4; i++) begin
            start_words[4 + 2*i] = key_cfg[i][31:0];
            start_words[5 + 2*i] = key_cfg[i][63:32];
        end
        start_words[12] = blk_ctr;
        start_words[13] = nonce1;
        start_words[14] = iv23_cfg[31:0];
        start_words[15] = iv23_cfg[63:32];
        for (int i = 0; i < 16; i++) mix[i] = start_words[i];
        for (int r = 0; r < ROUNDS / 2; r++) begin
            mix_quarter(0, 4, 8, 12);
            mix_quarter(1, 5, 9, 13);
            mix_quarter(2, 6, 10, 14);
            mix_quarter(3, 7, 11, 15);
            mix_quarter(0, 5, 10, 15);
            mix_quarter(1, 6, 11, 12);
            mix_quarter(2, 7, 8, 13);
            mix_quarter(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) begin
            w = mix[i] + start_words[i];
            ks_buf[4*i + 0] = w[7:0];
            ks_buf[4*i + 1] = w[15:8];
            ks_buf[4*i + 2] = w[23:16];
            ks_buf[4*i + 3] = w[31:24];
        end
        blocks_made++;
    endfunction

    // advance the shadow cipher by one accepted input beat
    function automatic void xor_keystream_beat(logic cmd, logic [7:0] data);
        if (cmd == CMD_RESTART) begin
            blk_ctr = iv01_cfg[31:0];
            nonce1  = iv01_cfg[63:32];
            ks_pos  = '0;
            restart_beats++;
        end else begin
            if (ks_pos == 0) refill_keystream();
            expected_out_bytes.push_back(data ^ ks_buf[ks_pos]);
            ks_pos = ks_pos + 1'b1;
            if (ks_pos == 0) begin
                blk_ctr = blk_ctr + 1;
                if (blk_ctr == 0) begin
                    ctr_wraps++;
                    nonce1 = nonce1 + 1;
                    if (nonce1 == 0) nonce_wraps++;
                end
            end
            data_beats++;
        end
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("MISMATCH %s at %0t: got %02h expected %02h", what, $time, got, want);
    endtask

    // sender
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_accepted) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_beat.data;
                s_tuser  <= next_beat.cmd;
                s_tlast  <= next_beat.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with an occasional long hold-off on request
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_hold_seen != rx_hold_requests) begin
                rx_hold_seen = rx_hold_requests;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // monitor, scoreboard and watchdog
    always @(posedge clk) begin
        s_accepted = 1'b0;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_out_bytes.size() == 0) begin
                    report_mismatch("unexpected out beat", m_tdata, 8'h00);
                end else begin
                    want_byte = expected_out_bytes.pop_front();
                    if (m_tdata !== want_byte) report_mismatch("out_byte", m_tdata, want_byte);
                end
            end
            if (s_tvalid && s_tready) begin
                s_accepted = 1'b1;
                xor_keystream_beat(s_tuser, s_tdata);
            end
            if (s_accepted || (m_tvalid && m_tready) ||
                (pending_beats.size() == 0 && !s_tvalid && expected_out_bytes.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic void queue_beat(logic cmd, logic [7:0] data, logic last);
        t_item b;
        b.cmd  = cmd;
        b.data = data;
        b.last = last;
        pending_beats.push_back(b);
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            REG_KEY01: key_cfg[0] = value;
            REG_KEY23: key_cfg[1] = value;
            REG_KEY45: key_cfg[2] = value;
            REG_KEY67: key_cfg[3] = value;
            REG_IV01:  iv01_cfg = value;
            REG_IV23:  iv23_cfg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // restart beats give no output, so settle a while after the last result
    task automatic wait_drained();
        do @(posedge clk);
        while (pending_beats.size() != 0 || s_tvalid || expected_out_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly framed messages of random length, with stray restarts mixed in
    task automatic run_traffic(int n_beats);
        int sent;
        int msg_len;
        sent = 0;
        queue_beat(CMD_RESTART, 8'($urandom), 1'($urandom));
        while (sent < n_beats) begin
            msg_len = $urandom_range(1, 90);
            if (msg_len > n_beats - sent)
                msg_len = n_beats - sent;
            for (int i = 0; i < msg_len; i++) begin
                if ($urandom_range(99) < 2)
                    queue_beat(CMD_RESTART, 8'($urandom), 1'($urandom));
                queue_beat(CMD_DATA, 8'($urandom), (i == msg_len - 1) ? 1'b1 : 1'($urandom_range(15) == 0));
                sent++;
            end
            if ($urandom_range(99) < 8)
                queue_beat(CMD_RESTART, 8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset state: zero key, counter and nonce
        queue_beat(CMD_DATA, 8'h00, 1'b0);
        queue_beat(CMD_DATA, 8'hFF, 1'b1);
        queue_beat(CMD_DATA, 8'hA5, 1'b0);
        queue_beat(CMD_RESTART, 8'h5A, 1'b1);
        queue_beat(CMD_DATA, 8'h3C, 1'b1);
        wait_drained();

        // new key mid-block: buffered bytes keep the old keystream until restart
        write_reg(REG_KEY01, '1);
        write_reg(REG_KEY23, '1);
        write_reg(REG_KEY45, '1);
        write_reg(REG_KEY67, '1);
        write_reg(REG_IV01, {$urandom, $urandom});
        write_reg(REG_IV23, '1);
        write_reg(REG_SPARE6, {$urandom, $urandom});
        write_reg(REG_SPARE7, '1);
        queue_beat(CMD_DATA, 8'h81, 1'b0);
        queue_beat(CMD_DATA, 8'h7E, 1'b0);
        queue_beat(CMD_DATA, 8'h01, 1'b1);
        queue_beat(CMD_RESTART, 8'h00, 1'b0);
        queue_beat(CMD_DATA, 8'h80, 1'b0);
        queue_beat(CMD_DATA, 8'h40, 1'b0);
        queue_beat(CMD_DATA, 8'h02, 1'b0);
        queue_beat(CMD_DATA, 8'hC3, 1'b1);
        wait_drained();

        write_reg(REG_KEY01, {$urandom, $urandom});
        write_reg(REG_KEY45, '0);
        write_reg(REG_IV23, '0);
        queue_beat(CMD_RESTART, 8'hFF, 1'b0);
        queue_beat(CMD_DATA, 8'h55, 1'b0);
        queue_beat(CMD_DATA, 8'hAA, 1'b1);
        wait_drained();

        // counter and nonce both at all ones: the first block boundary wraps both
        write_reg(REG_KEY01, {$urandom, $urandom});
        write_reg(REG_KEY23, {$urandom, $urandom});
        write_reg(REG_KEY45, {$urandom, $urandom});
        write_reg(REG_KEY67, {$urandom, $urandom});
        write_reg(REG_IV01, '1);
        write_reg(REG_IV23, {$urandom, $urandom});
        run_traffic(170);
        rx_hold_requests++;
        wait_drained();

        tx_idle_pct = 75;
        rx_idle_pct = 21;
        write_reg(REG_KEY01, {$urandom, $urandom});
        write_reg(REG_KEY23, '0);
        write_reg(REG_KEY67, {$urandom, $urandom});
        write_reg(REG_IV01, {$urandom, 32'hFFFF_FFFF});
        write_reg(REG_IV23, '0);
        write_reg(REG_SPARE7, {$urandom, $urandom});
        run_traffic(170);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(REG_KEY23, {$urandom, $urandom});
        write_reg(REG_KEY45, {$urandom, $urandom});
        write_reg(REG_KEY67, '0);
        write_reg(REG_IV01, {32'hFFFF_FFFF, 32'hFFFF_FFFE});
        write_reg(REG_IV23, '1);
        run_traffic(170);
        wait_drained();

        $display("run covered %0d data beats, %0d restarts, %0d keystream blocks",
                 data_beats, restart_beats, blocks_made);
        $display("block counter wraps %0d, nonce wraps %0d, mismatches %0d",
                 ctr_wraps, nonce_wraps, err_count);
        if (err_count == 0 && expected_out_bytes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ chacha20_keystream_xor.f @@
+incdir+hw/rtl
hw/rtl/chx_pkg.sv
hw/rtl/chx_front.sv
hw/rtl/chx_core.sv
hw/rtl/chacha20_keystream_xor.sv
hw/rtl/chx_checker.sv
tb/sv/testbench.sv
